[rtl/tli_pkg.sv]
// Shared types and constants of the table Lagrange interpolator.
package tli_pkg;

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Range codes of a result.
  localparam logic [1:0] RANGE_INSIDE = 2'd0;
  localparam logic [1:0] RANGE_BELOW  = 2'd1;
  localparam logic [1:0] RANGE_ABOVE  = 2'd2;

  // Table size; entry indexes and brackets are 12 bits wide.
  localparam int TABLE_DEPTH = 4096;

  // Window geometry.
  localparam int WINDOW = 5;
  localparam int HALF   = 2;

  // Wide integer datapath of the term unit.
  localparam int BIG_W     = 192;
  localparam int MUL_BITS  = 33;
  localparam int QUOT_BITS = 47;
  localparam int ACC_W     = 51;
  localparam int BCNT_W    = 6;

  localparam logic [QUOT_BITS-1:0] TERM_MAX = {QUOT_BITS{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_HINT,
    ST_PROBE,
    ST_EVAL,
    ST_BIS,
    ST_BRACKET,
    ST_WIN_RD,
    ST_WIN_CAP,
    ST_DEGEN,
    ST_TERM_INIT,
    ST_MUL_SETUP,
    ST_MUL,
    ST_DIV_SETUP,
    ST_DIV,
    ST_TERM_ACC,
    ST_FINAL
  } state_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_UP,
    PH_DN,
    PH_BISP
  } phase_e;

endpackage

[rtl/tli_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/table_lagrange_interpolator_top.sv]
// Top level of the five-point Lagrange table interpolator.
//
// The input channel (in_valid_i / in_ready_o) carries two kinds of item. A load
// item (op_i = 0) writes one abscissa/ordinate pair into the table at
// entry_index_i; it is written at its transfer and gives no result. A query item
// (op_i = 1) finds the bracket of query_point_i by a hunt search that starts
// from the previous bracket, reads a five-entry window around it and sums the
// five rounded Lagrange terms, giving one result transfer on the output
// channel (out_valid_o / out_ready_i).
// Besides its search, a query spends time on table reads, window fetch and
// hand-off, and on five terms on the shared bit-serial unit, each with four
// multiply passes, a 47-step restoring division and setup and accumulation. A
// clipped term skips its division, and a window with two equal abscissas skips
// all terms. A hunt probe in the search goes through ST_PROBE and ST_EVAL, a
// bisection step through ST_BIS, ST_PROBE and ST_EVAL; the bisection closes in ST_BIS.
// The block takes one item at a time; in_ready_o is high only while idle.
// A finished result sits in an output register, so the next item is accepted
// while the receiver stalls; a second result waits in its last step until the
// output register has been emptied. Reset clears the search hint and sets the
// point count to 4096; table contents are undefined until loaded.
module table_lagrange_interpolator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [12:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [11:0]        entry_index_i,
  input  logic signed [31:0] entry_abscissa_i,
  input  logic signed [31:0] entry_ordinate_i,
  input  logic signed [31:0] query_point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic [11:0]        bracket_o,
  output logic [1:0]         range_code_o,
  output logic               saturated_o
);

  localparam int AW = $clog2(tli_pkg::TABLE_DEPTH);
  localparam int IW = AW + 3;
  localparam int W  = tli_pkg::BIG_W;
  localparam int QW = tli_pkg::QUOT_BITS;

  // Control state.
  tli_pkg::state_e state_q, state_d;
  tli_pkg::phase_e phase_q, phase_d;
  logic            out_valid_q, out_valid_d;
  logic [11:0]     hint_q, hint_d;
  logic [12:0]     pc_q, pc_d;

  // Search registers.
  logic signed [IW-1:0] n_q, n_d, lo_q, lo_d, hi_q, hi_d, inc_q, inc_d;
  logic signed [IW-1:0] probe_q, probe_d, k_q, k_d;
  logic signed [31:0]   q_q, q_d, x0_q, x0_d;
  logic                 asc_q, asc_d;
  logic [1:0]           code_q, code_d;
  logic [2:0]           wcnt_q, wcnt_d, jcnt_q, jcnt_d;
  logic [1:0]           fcnt_q, fcnt_d;

  // Window and term unit.
  logic signed [31:0]     wx_q [tli_pkg::WINDOW];
  logic signed [31:0]     wx_d [tli_pkg::WINDOW];
  logic signed [31:0]     wy_q [tli_pkg::WINDOW];
  logic signed [31:0]     wy_d [tli_pkg::WINDOW];
  logic signed [31:0]     sx_q [tli_pkg::WINDOW-1];
  logic signed [31:0]     sx_d [tli_pkg::WINDOW-1];
  logic                   neg_q, neg_d, sat_q, sat_d;
  logic [W-1:0]           num_q, num_d, den_q, den_d, mcn_q, mcn_d, mcd_q, mcd_d;
  logic [W-1:0]           rem_q, rem_d, dv_q, dv_d;
  logic [tli_pkg::MUL_BITS-1:0] ma_q, ma_d, mb_q, mb_d;
  logic [tli_pkg::BCNT_W-1:0]   bcnt_q, bcnt_d;
  logic [QW-1:0]          quot_q, quot_d;
  logic signed [tli_pkg::ACC_W-1:0] acc_q, acc_d;

  // Output register.
  logic signed [31:0] val_q, val_d;
  logic [11:0]        brk_q, brk_d;
  logic [1:0]         rc_q, rc_d;
  logic               osat_q, osat_d;

  // Table port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_rdata;
  logic signed [31:0] rd_x, rd_y;

  logic in_xfer, load_xfer, query_xfer, out_free;
  logic ge, degen;
  logic signed [IW-1:0] n_clamp, nm1, inc2, up_hi, mid, kraw;
  logic signed [32:0]   fa, fb;
  logic [W-1:0]         rem_init, den_sh48;
  logic                 big, div_ge;
  logic signed [tli_pkg::ACC_W-1:0] term;

  assign in_ready_o = (state_q == tli_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_xfer  = in_xfer && (op_i == tli_pkg::OP_LOAD);
  assign query_xfer = in_xfer && (op_i == tli_pkg::OP_QUERY);
  assign out_free   = !out_valid_q || out_ready_i;

  // Loads beyond the table depth are dropped.
  assign ram_we    = load_xfer && (32'(entry_index_i) < 32'(tli_pkg::TABLE_DEPTH));
  assign ram_waddr = AW'(entry_index_i);

  tli_ram #(
    .WIDTH(64),
    .DEPTH(tli_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({entry_ordinate_i, entry_abscissa_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_x = ram_rdata[31:0];
  assign rd_y = ram_rdata[63:32];

  // The point count in use is the register clamped to the window and depth.
  always_comb begin
    if (32'(pc_q) < 32'(tli_pkg::WINDOW)) begin
      n_clamp = IW'(tli_pkg::WINDOW);
    end else if (32'(pc_q) > 32'(tli_pkg::TABLE_DEPTH)) begin
      n_clamp = IW'(tli_pkg::TABLE_DEPTH);
    end else begin
      n_clamp = IW'(pc_q);
    end
  end

  // Search helpers. On a descending table the comparison is inverted.
  assign ge    = ((q_q >= rd_x) == asc_q);
  assign nm1   = n_q - IW'(1);
  assign inc2  = inc_q <<< 1;
  assign up_hi = hi_q + inc2;
  assign mid   = (hi_q + lo_q) >>> 1;
  assign kraw  = lo_q - IW'(tli_pkg::HALF);

  // Two equal abscissas anywhere in the window make it unusable.
  always_comb begin
    degen = 1'b0;
    for (int a = 0; a < tli_pkg::WINDOW; a++) begin
      for (int b = a + 1; b < tli_pkg::WINDOW; b++) begin
        if (wx_q[a] == wx_q[b]) begin
          degen = 1'b1;
        end
      end
    end
  end

  // Term unit helpers.
  assign fa       = {q_q[31], q_q} - {sx_q[0][31], sx_q[0]};
  assign fb       = {wx_q[0][31], wx_q[0]} - {sx_q[0][31], sx_q[0]};
  assign rem_init = {num_q[W-2:0], 1'b0} + den_q;
  assign den_sh48 = den_q << (QW + 1);
  assign big      = (rem_init >= den_sh48);
  assign div_ge   = (rem_q >= dv_q);
  assign term     = neg_q ? -$signed({4'b0000, quot_q}) : $signed({4'b0000, quot_q});

  // Table read address.
  always_comb begin
    case (state_q)
      tli_pkg::ST_RD_FIRST: ram_raddr = '0;
      tli_pkg::ST_RD_LAST:  ram_raddr = AW'(nm1);
      tli_pkg::ST_PROBE:    ram_raddr = AW'(probe_q);
      tli_pkg::ST_WIN_RD:   ram_raddr = AW'(k_q + IW'(wcnt_q));
      default:              ram_raddr = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tli_pkg::ST_IDLE: begin
        if (query_xfer) begin
          state_d = tli_pkg::ST_RD_FIRST;
        end
      end
      tli_pkg::ST_RD_FIRST: state_d = tli_pkg::ST_RD_LAST;
      tli_pkg::ST_RD_LAST:  state_d = tli_pkg::ST_HINT;
      tli_pkg::ST_HINT: begin
        if ($signed({{(IW-12){1'b0}}, hint_q}) > nm1) begin
          state_d = tli_pkg::ST_BIS;
        end else begin
          state_d = tli_pkg::ST_PROBE;
        end
      end
      tli_pkg::ST_PROBE: state_d = tli_pkg::ST_EVAL;
      tli_pkg::ST_EVAL: begin
        case (phase_q)
          tli_pkg::PH_START: begin
            if (ge) begin
              state_d = (lo_q == nm1) ? tli_pkg::ST_BRACKET : tli_pkg::ST_PROBE;
            end else begin
              state_d = (lo_q == '0) ? tli_pkg::ST_BRACKET : tli_pkg::ST_PROBE;
            end
          end
          tli_pkg::PH_UP: begin
            if (ge && !(up_hi > nm1)) begin
              state_d = tli_pkg::ST_PROBE;
            end else begin
              state_d = tli_pkg::ST_BIS;
            end
          end
          tli_pkg::PH_DN: begin
            if (!ge && !(inc2 >= lo_q)) begin
              state_d = tli_pkg::ST_PROBE;
            end else begin
              state_d = tli_pkg::ST_BIS;
            end
          end
          default: state_d = tli_pkg::ST_BIS;
        endcase
      end
      tli_pkg::ST_BIS: begin
        if (hi_q - lo_q == IW'(1)) begin
          state_d = tli_pkg::ST_BRACKET;
        end else begin
          state_d = tli_pkg::ST_PROBE;
        end
      end
      tli_pkg::ST_BRACKET: state_d = tli_pkg::ST_WIN_RD;
      tli_pkg::ST_WIN_RD:  state_d = tli_pkg::ST_WIN_CAP;
      tli_pkg::ST_WIN_CAP: begin
        if (wcnt_q == 3'(tli_pkg::WINDOW - 1)) begin
          state_d = tli_pkg::ST_DEGEN;
        end else begin
          state_d = tli_pkg::ST_WIN_RD;
        end
      end
      tli_pkg::ST_DEGEN: state_d = degen ? tli_pkg::ST_FINAL : tli_pkg::ST_TERM_INIT;
      tli_pkg::ST_TERM_INIT: state_d = tli_pkg::ST_MUL_SETUP;
      tli_pkg::ST_MUL_SETUP: state_d = tli_pkg::ST_MUL;
      tli_pkg::ST_MUL: begin
        if (bcnt_q == tli_pkg::BCNT_W'(tli_pkg::MUL_BITS - 1)) begin
          if (fcnt_q == 2'(tli_pkg::WINDOW - 2)) begin
            state_d = tli_pkg::ST_DIV_SETUP;
          end else begin
            state_d = tli_pkg::ST_MUL_SETUP;
          end
        end
      end
      tli_pkg::ST_DIV_SETUP: state_d = big ? tli_pkg::ST_TERM_ACC : tli_pkg::ST_DIV;
      tli_pkg::ST_DIV: begin
        if (bcnt_q == tli_pkg::BCNT_W'(QW - 1)) begin
          state_d = tli_pkg::ST_TERM_ACC;
        end
      end
      tli_pkg::ST_TERM_ACC: begin
        if (jcnt_q == 3'(tli_pkg::WINDOW - 1)) begin
          state_d = tli_pkg::ST_FINAL;
        end else begin
          state_d = tli_pkg::ST_TERM_INIT;
        end
      end
      tli_pkg::ST_FINAL: begin
        if (out_free) begin
          state_d = tli_pkg::ST_IDLE;
        end
      end
      default: state_d = tli_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    hint_d      = hint_q;
    pc_d        = pc_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    inc_d       = inc_q;
    probe_d     = probe_q;
    k_d         = k_q;
    q_d         = q_q;
    x0_d        = x0_q;
    asc_d       = asc_q;
    code_d      = code_q;
    wcnt_d      = wcnt_q;
    jcnt_d      = jcnt_q;
    fcnt_d      = fcnt_q;
    wx_d        = wx_q;
    wy_d        = wy_q;
    sx_d        = sx_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    num_d       = num_q;
    den_d       = den_q;
    mcn_d       = mcn_q;
    mcd_d       = mcd_q;
    rem_d       = rem_q;
    dv_d        = dv_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    bcnt_d      = bcnt_q;
    quot_d      = quot_q;
    acc_d       = acc_q;
    val_d       = val_q;
    brk_d       = brk_q;
    rc_d        = rc_q;
    osat_d      = osat_q;

    if (cfg_we_i) begin
      pc_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tli_pkg::ST_IDLE: begin
        if (query_xfer) begin
          q_d = query_point_i;
          n_d = n_clamp;
        end
      end
      tli_pkg::ST_RD_LAST: begin
        x0_d = rd_x;
      end
      tli_pkg::ST_HINT: begin
        asc_d = (rd_x > x0_q);
        inc_d = IW'(1);
        if ($signed({{(IW-12){1'b0}}, hint_q}) > nm1) begin
          lo_d = -IW'(1);
          hi_d = n_q;
        end else begin
          lo_d    = $signed({{(IW-12){1'b0}}, hint_q});
          probe_d = $signed({{(IW-12){1'b0}}, hint_q});
          phase_d = tli_pkg::PH_START;
        end
      end
      tli_pkg::ST_EVAL: begin
        case (phase_q)
          tli_pkg::PH_START: begin
            if (ge) begin
              if (lo_q != nm1) begin
                hi_d    = lo_q + IW'(1);
                probe_d = lo_q + IW'(1);
                phase_d = tli_pkg::PH_UP;
              end
            end else if (lo_q == '0) begin
              lo_d = -IW'(1);
            end else begin
              hi_d    = lo_q;
              lo_d    = lo_q - IW'(1);
              probe_d = lo_q - IW'(1);
              phase_d = tli_pkg::PH_DN;
            end
          end
          tli_pkg::PH_UP: begin
            if (ge) begin
              lo_d  = hi_q;
              inc_d = inc2;
              if (up_hi > nm1) begin
                hi_d = n_q;
              end else begin
                hi_d    = up_hi;
                probe_d = up_hi;
              end
            end
          end
          tli_pkg::PH_DN: begin
            if (!ge) begin
              hi_d  = lo_q;
              inc_d = inc2;
              if (inc2 >= lo_q) begin
                lo_d = -IW'(1);
              end else begin
                lo_d    = lo_q - inc2;
                probe_d = lo_q - inc2;
              end
            end
          end
          default: begin
            if (ge) begin
              lo_d = probe_q;
            end else begin
              hi_d = probe_q;
            end
          end
        endcase
      end
      tli_pkg::ST_BIS: begin
        if (hi_q - lo_q != IW'(1)) begin
          probe_d = mid;
          phase_d = tli_pkg::PH_BISP;
        end
      end
      tli_pkg::ST_BRACKET: begin
        hint_d = lo_q[IW-1] ? 12'd0 : 12'(lo_q);
        if (lo_q[IW-1]) begin
          code_d = tli_pkg::RANGE_BELOW;
        end else if (lo_q == nm1) begin
          code_d = tli_pkg::RANGE_ABOVE;
        end else begin
          code_d = tli_pkg::RANGE_INSIDE;
        end
        // Clamp the window into the table.
        if (kraw[IW-1]) begin
          k_d = '0;
        end else if (kraw > n_q - IW'(tli_pkg::WINDOW)) begin
          k_d = n_q - IW'(tli_pkg::WINDOW);
        end else begin
          k_d = kraw;
        end
        wcnt_d = '0;
      end
      tli_pkg::ST_WIN_CAP: begin
        for (int i = 0; i < tli_pkg::WINDOW - 1; i++) begin
          wx_d[i] = wx_q[i+1];
          wy_d[i] = wy_q[i+1];
        end
        wx_d[tli_pkg::WINDOW-1] = rd_x;
        wy_d[tli_pkg::WINDOW-1] = rd_y;
        wcnt_d = wcnt_q + 3'd1;
      end
      tli_pkg::ST_DEGEN: begin
        acc_d  = '0;
        sat_d  = degen;
        jcnt_d = '0;
      end
      tli_pkg::ST_TERM_INIT: begin
        // The current node sits in window slot 0; the others feed the factors.
        // The magnitude is zero-extended so the most negative ordinate gives 2^31.
        num_d  = W'($unsigned(wy_q[0][31] ? 32'(-wy_q[0]) : 32'(wy_q[0])));
        den_d  = W'(1);
        neg_d  = wy_q[0][31];
        fcnt_d = '0;
        for (int i = 0; i < tli_pkg::WINDOW - 1; i++) begin
          sx_d[i] = wx_q[i+1];
        end
      end
      tli_pkg::ST_MUL_SETUP: begin
        ma_d   = fa[32] ? 33'(-fa) : 33'(fa);
        mb_d   = fb[32] ? 33'(-fb) : 33'(fb);
        neg_d  = neg_q ^ fa[32] ^ fb[32];
        mcn_d  = num_q;
        mcd_d  = den_q;
        num_d  = '0;
        den_d  = '0;
        bcnt_d = '0;
      end
      tli_pkg::ST_MUL: begin
        num_d  = {num_q[W-2:0], 1'b0} + (ma_q[tli_pkg::MUL_BITS-1] ? mcn_q : '0);
        den_d  = {den_q[W-2:0], 1'b0} + (mb_q[tli_pkg::MUL_BITS-1] ? mcd_q : '0);
        ma_d   = ma_q << 1;
        mb_d   = mb_q << 1;
        bcnt_d = bcnt_q + tli_pkg::BCNT_W'(1);
        if (bcnt_q == tli_pkg::BCNT_W'(tli_pkg::MUL_BITS - 1)) begin
          for (int i = 0; i < tli_pkg::WINDOW - 2; i++) begin
            sx_d[i] = sx_q[i+1];
          end
          fcnt_d = fcnt_q + 2'd1;
        end
      end
      tli_pkg::ST_DIV_SETUP: begin
        // Rounded quotient of num / den is floor((2 num + den) / (2 den)).
        rem_d  = rem_init;
        dv_d   = den_q << QW;
        quot_d = '0;
        bcnt_d = '0;
        if (big) begin
          quot_d = tli_pkg::TERM_MAX;
          sat_d  = 1'b1;
        end
      end
      tli_pkg::ST_DIV: begin
        rem_d  = div_ge ? rem_q - dv_q : rem_q;
        quot_d = {quot_q[QW-2:0], div_ge};
        dv_d   = dv_q >> 1;
        bcnt_d = bcnt_q + tli_pkg::BCNT_W'(1);
      end
      tli_pkg::ST_TERM_ACC: begin
        acc_d = acc_q + term;
        for (int i = 0; i < tli_pkg::WINDOW - 1; i++) begin
          wx_d[i] = wx_q[i+1];
          wy_d[i] = wy_q[i+1];
        end
        wx_d[tli_pkg::WINDOW-1] = wx_q[0];
        wy_d[tli_pkg::WINDOW-1] = wy_q[0];
        jcnt_d = jcnt_q + 3'd1;
      end
      tli_pkg::ST_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          brk_d       = hint_q;
          rc_d        = code_q;
          if (acc_q > tli_pkg::ACC_W'(32'sh7FFF_FFFF)) begin
            val_d  = 32'sh7FFF_FFFF;
            osat_d = 1'b1;
          end else if (acc_q < $signed({{(tli_pkg::ACC_W-32){1'b1}}, 32'h8000_0000})) begin
            val_d  = 32'sh8000_0000;
            osat_d = 1'b1;
          end else begin
            val_d  = acc_q[31:0];
            osat_d = sat_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tli_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      hint_q      <= '0;
      pc_q        <= 13'd4096;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hint_q      <= hint_d;
      pc_q        <= pc_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    n_q     <= n_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    inc_q   <= inc_d;
    probe_q <= probe_d;
    k_q     <= k_d;
    q_q     <= q_d;
    x0_q    <= x0_d;
    asc_q   <= asc_d;
    code_q  <= code_d;
    wcnt_q  <= wcnt_d;
    jcnt_q  <= jcnt_d;
    fcnt_q  <= fcnt_d;
    wx_q    <= wx_d;
    wy_q    <= wy_d;
    sx_q    <= sx_d;
    neg_q   <= neg_d;
    sat_q   <= sat_d;
    num_q   <= num_d;
    den_q   <= den_d;
    mcn_q   <= mcn_d;
    mcd_q   <= mcd_d;
    rem_q   <= rem_d;
    dv_q    <= dv_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    bcnt_q  <= bcnt_d;
    quot_q  <= quot_d;
    acc_q   <= acc_d;
    val_q   <= val_d;
    brk_q   <= brk_d;
    rc_q    <= rc_d;
    osat_q  <= osat_d;
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = val_q;
  assign bracket_o    = brk_q;
  assign range_code_o = rc_q;
  assign saturated_o  = osat_q;

endmodule

[tb/tb.sv]
// Self-checking testbench for the five-point Lagrange table interpolator.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH      = 4096;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_SPAN  = 3000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] XMIN = 32'sh8000_0000;
  localparam logic signed [31:0] XMAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [31:0] value;
    logic [11:0]        bracket;
    logic [1:0]         code;
    logic               sat;
  } result_t;

  typedef struct {
    logic               op;
    logic [11:0]        idx;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] q;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Block ports; every input starts at a known value.
  logic               cfg_we_i = 1'b0;
  logic [12:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               op_i = tli_pkg::OP_LOAD;
  logic [11:0]        entry_index_i = '0;
  logic signed [31:0] entry_abscissa_i = '0;
  logic signed [31:0] entry_ordinate_i = '0;
  logic signed [31:0] query_point_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic [11:0]        bracket_o;
  logic [1:0]         range_code_o;
  logic               saturated_o;

  table_lagrange_interpolator_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .entry_index_i    (entry_index_i),
    .entry_abscissa_i (entry_abscissa_i),
    .entry_ordinate_i (entry_ordinate_i),
    .query_point_i    (query_point_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .bracket_o        (bracket_o),
    .range_code_o     (range_code_o),
    .saturated_o      (saturated_o)
  );

  // Shadow copy of the table, the search hint and the point count.
  logic signed [31:0] abscissa_mdl [DEPTH];
  logic signed [31:0] ordinate_mdl [DEPTH];
  int                 hint_mdl = 0;
  int                 count_mdl = DEPTH;

  // Results that the block still owes, oldest first.
  result_t pending_results [$];

  int  mismatches = 0;
  int  loads_sent = 0;
  int  queries_sent = 0;
  int  results_seen = 0;
  int  clipped_seen = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  // True when the query lies at or beyond entry j in the table's direction.
  function automatic bit past_entry(input logic signed [31:0] q, input int j, input bit asc);
    return (q >= abscissa_mdl[j]) == asc;
  endfunction

  // Hunt from the previous bracket, then bisect; -1 means before the table.
  function automatic int locate(input logic signed [31:0] q, input int n, input int start,
                                input bit asc);
    int lo, hi, inc, m;
    lo  = start;
    hi  = 0;
    inc = 1;
    if (lo < 0 || lo > n - 1) begin
      lo = -1;
      hi = n;
    end else if (past_entry(q, lo, asc)) begin
      if (lo == n - 1) return lo;
      hi = lo + 1;
      while (past_entry(q, hi, asc)) begin
        lo  = hi;
        inc = inc + inc;
        hi  = lo + inc;
        if (hi > n - 1) begin
          hi = n;
          break;
        end
      end
    end else begin
      if (lo == 0) return -1;
      hi = lo;
      lo = lo - 1;
      while (!past_entry(q, lo, asc)) begin
        hi  = lo;
        inc = inc << 1;
        if (inc >= hi) begin
          lo = -1;
          break;
        end
        lo = hi - inc;
      end
    end
    while (hi - lo != 1) begin
      m = (hi + lo) >>> 1;
      if (past_entry(q, m, asc)) lo = m;
      else hi = m;
    end
    return lo;
  endfunction

  // Expected result of one query; advances the shadow search hint.
  function automatic result_t interpolate(input logic signed [31:0] q);
    result_t     r;
    int          n, lo, k, i, j;
    bit          asc, degen, neg;
    longint      acc, y, a, b;
    logic [191:0] num, den, quo;
    n = count_mdl;
    if (n < tli_pkg::WINDOW) n = tli_pkg::WINDOW;
    if (n > DEPTH) n = DEPTH;
    asc = abscissa_mdl[n-1] > abscissa_mdl[0];
    lo = locate(q, n, hint_mdl, asc);
    hint_mdl = (lo < 0) ? 0 : lo;
    r.bracket = 12'(hint_mdl);
    r.code = (lo < 0) ? tli_pkg::RANGE_BELOW :
             ((lo == n - 1) ? tli_pkg::RANGE_ABOVE : tli_pkg::RANGE_INSIDE);
    r.sat = 1'b0;
    k = lo - tli_pkg::HALF;
    if (k < 0) k = 0;
    if (k > n - tli_pkg::WINDOW) k = n - tli_pkg::WINDOW;
    degen = 1'b0;
    for (j = 0; j < tli_pkg::WINDOW; j++)
      for (i = j + 1; i < tli_pkg::WINDOW; i++)
        if (abscissa_mdl[k+i] == abscissa_mdl[k+j]) degen = 1'b1;
    if (degen) begin
      r.value = '0;
      r.sat = 1'b1;
      return r;
    end
    acc = 0;
    for (j = 0; j < tli_pkg::WINDOW; j++) begin
      y   = ordinate_mdl[k+j];
      neg = y < 0;
      num = 192'(y < 0 ? -y : y);
      den = 192'(1);
      for (i = 0; i < tli_pkg::WINDOW; i++) begin
        if (i != j) begin
          a = longint'(q) - longint'(abscissa_mdl[k+i]);
          b = longint'(abscissa_mdl[k+j]) - longint'(abscissa_mdl[k+i]);
          if (a < 0) neg = !neg;
          if (b < 0) neg = !neg;
          num = num * 192'(a < 0 ? -a : a);
          den = den * 192'(b < 0 ? -b : b);
        end
      end
      // Round half away from zero on the magnitude.
      quo = ((num << 1) + den) / (den << 1);
      if (quo >= (192'(1) << tli_pkg::QUOT_BITS)) begin
        quo = 192'(tli_pkg::TERM_MAX);
        r.sat = 1'b1;
      end
      acc = neg ? acc - longint'(quo[63:0]) : acc + longint'(quo[63:0]);
    end
    if (acc > longint'(XMAX)) begin
      acc = XMAX;
      r.sat = 1'b1;
    end
    if (acc < longint'(XMIN)) begin
      acc = XMIN;
      r.sat = 1'b1;
    end
    r.value = acc[31:0];
    return r;
  endfunction

  // Offer one item and hold it until the transfer; valid is left high.
  task automatic offer(input stim_row_t s);
    result_t r;
    in_valid_i       <= 1'b1;
    op_i             <= s.op;
    entry_index_i    <= s.idx;
    entry_abscissa_i <= s.ax;
    entry_ordinate_i <= s.ay;
    query_point_i    <= s.q;
    do @(posedge clk_i); while (!in_ready_o);
    if (s.op == tli_pkg::OP_LOAD) begin
      abscissa_mdl[s.idx] = s.ax;
      ordinate_mdl[s.idx] = s.ay;
      loads_sent++;
    end else begin
      r = interpolate(s.q);
      pending_results.push_back(s.typed ? s.want : r);
      queries_sent++;
    end
  endtask

  // Random sender gaps, skipped during the calm stretch.
  task automatic sender_gap();
    if (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Let every owed result arrive and the last load settle, then leave the block idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [12:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    count_mdl = v;
  endtask

  function automatic stim_row_t load_row(input int idx, input logic signed [31:0] ax,
                                         input logic signed [31:0] ay);
    stim_row_t s;
    s = '{op: tli_pkg::OP_LOAD, idx: 12'(idx), ax: ax, ay: ay, q: '0, typed: 1'b0,
          want: '{value: '0, bracket: '0, code: tli_pkg::RANGE_INSIDE, sat: 1'b0}};
    return s;
  endfunction

  function automatic stim_row_t query_row(input logic signed [31:0] q, input bit typed,
                                          input logic signed [31:0] v, input int br,
                                          input logic [1:0] code, input logic sat);
    stim_row_t s;
    s = '{op: tli_pkg::OP_QUERY, idx: '0, ax: '0, ay: '0, q: q, typed: typed,
          want: '{value: v, bracket: 12'(br), code: code, sat: sat}};
    return s;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(XMAX)) return XMAX;
    if (v < longint'(XMIN)) return XMIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] rand_ordinate();
    if ($urandom_range(1)) return $urandom;
    return $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
  endfunction

  // Fill entries 0..n-1 with a monotonic table of random shape and direction.
  task automatic load_table(input int n);
    longint   step_max, pos, steps [DEPTH];
    bit       desc;
    int       j;
    stim_row_t s;
    desc = $urandom_range(1);
    if ($urandom_range(1)) begin
      step_max = 64'h0_FFFF_FFFF / n;
      pos = longint'(XMIN);
    end else begin
      step_max = $urandom_range(1, 1 << 18);
      pos = longint'(XMIN) + longint'($urandom_range(0, 32'hFFFF_FFFF - 32'(n * step_max)));
    end
    for (j = 0; j < n; j++) begin
      steps[j] = pos;
      // A rare zero step leaves two equal abscissas in some window.
      if ($urandom_range(99) >= 2) pos = pos + longint'($urandom_range(1, 32'(step_max)));
    end
    for (j = 0; j < n; j++) begin
      s = load_row(j, clamp32(steps[desc ? n - 1 - j : j]), rand_ordinate());
      offer(s);
      sender_gap();
    end
  endtask

  function automatic logic signed [31:0] rand_query(input int n);
    int     j;
    longint a, b, lo_v, hi_v;
    int     pick;
    pick = $urandom_range(99);
    j = $urandom_range(0, n - 2);
    a = abscissa_mdl[j];
    b = abscissa_mdl[j+1];
    lo_v = (a < b) ? a : b;
    hi_v = (a < b) ? b : a;
    if (pick < 60)
      return clamp32(lo_v + longint'($urandom_range(0, 32'(hi_v - lo_v))));
    if (pick < 75) return a[31:0];
    if (pick < 85) return $urandom;
    if (pick < 93)
      return clamp32(longint'(abscissa_mdl[0]) +
                     ($urandom_range(1) ? 1 : -1) * longint'($urandom_range(1, 1 << 20)));
    return clamp32(longint'(abscissa_mdl[n-1]) +
                   ($urandom_range(1) ? 1 : -1) * longint'($urandom_range(1, 1 << 20)));
  endfunction

  // Random mix of queries and loads; loads keep every entry in use written.
  task automatic random_items(input int n, input int count, input int phase);
    stim_row_t s;
    int        i, j;
    for (i = 0; i < count; i++) begin
      if (phase == 1 && i == 100) hold_req = 1'b1;
      if (phase == 3 && i == 100) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(99) < 50) begin
        s = query_row(rand_query(n), 1'b0, '0, 0, tli_pkg::RANGE_INSIDE, 1'b0);
      end else if (n < DEPTH && $urandom_range(1)) begin
        s = load_row($urandom_range(n, DEPTH - 1), $urandom, $urandom);
      end else begin
        j = $urandom_range(0, n - 1);
        if ($urandom_range(99) < 8) s = load_row(j, $urandom, rand_ordinate());
        else s = load_row(j, abscissa_mdl[j], rand_ordinate());
      end
      offer(s);
      sender_gap();
    end
  endtask

  // Receiver: random stalls, a calm stretch, and one long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_SPAN) @(posedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  result_t want_r;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (saturated_o) clipped_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing expected: value %h bracket %0d code %0d sat %b",
                   value_o, bracket_o, range_code_o, saturated_o);
      end else begin
        want_r = pending_results.pop_front();
        if (value_o !== want_r.value || bracket_o !== want_r.bracket ||
            range_code_o !== want_r.code || saturated_o !== want_r.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d: expected value %h bracket %0d code %0d sat %b, got value %h bracket %0d code %0d sat %b",
                     results_seen, want_r.value, want_r.bracket, want_r.code, want_r.sat,
                     value_o, bracket_o, range_code_o, saturated_o);
        end
      end
    end
  end

  // Watchdog: a long run of cycles without any transfer ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
        $display("table_lagrange_interpolator_top verification failed");
        $finish;
      end
    end
  end

  stim_row_t directed [$];
  int        counts [6] = '{0, 23, 400, 120, 7, 64};

  initial begin
    int p, n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_count(13'd5);

    // Ascending unit-spaced table; queries on nodes read the ordinate back exactly.
    for (int k = 0; k < 5; k++) directed.push_back(load_row(k, ONE * k, ONE * (10 * k + 10)));
    directed.push_back(query_row(ONE * 2, 1'b1, ONE * 30, 2, tli_pkg::RANGE_INSIDE, 1'b0));
    directed.push_back(query_row(ONE * 4, 1'b1, ONE * 50, 4, tli_pkg::RANGE_ABOVE, 1'b0));
    directed.push_back(query_row(32'sd0, 1'b1, ONE * 10, 0, tli_pkg::RANGE_INSIDE, 1'b0));
    // Far outside on both sides: the terms blow up and clip.
    directed.push_back(query_row(XMIN, 1'b0, '0, 0, tli_pkg::RANGE_BELOW, 1'b0));
    directed.push_back(query_row(XMAX, 1'b0, '0, 0, tli_pkg::RANGE_ABOVE, 1'b0));
    // Two equal abscissas in the window give a zero, clipped value.
    directed.push_back(load_row(1, 32'sd0, ONE * 20));
    directed.push_back(query_row(ONE * 3, 1'b1, 32'sd0, 3, tli_pkg::RANGE_INSIDE, 1'b1));
    directed.push_back(load_row(4095, XMIN, XMAX));
    // Descending table.
    for (int k = 0; k < 5; k++)
      directed.push_back(load_row(k, ONE * (4 - k), ONE * (10 * k + 10)));
    directed.push_back(query_row(ONE, 1'b1, ONE * 40, 2, tli_pkg::RANGE_INSIDE, 1'b0));
    // Table spanning the full abscissa range with extreme ordinates.
    directed.push_back(load_row(0, XMIN, XMIN));
    directed.push_back(load_row(1, -32'sd1, XMAX));
    directed.push_back(load_row(2, 32'sd0, 32'sd7));
    directed.push_back(load_row(3, 32'sd1, -32'sd7));
    directed.push_back(load_row(4, XMAX, 32'sd0));
    directed.push_back(query_row(32'sd0, 1'b1, 32'sd7, 2, tli_pkg::RANGE_INSIDE, 1'b0));
    foreach (directed[i]) begin
      offer(directed[i]);
      sender_gap();
    end

    // Random phases, each with its own point count, a count below range included.
    for (p = 0; p < 6; p++) begin
      drain();
      write_count(13'(counts[p]));
      n = counts[p] < tli_pkg::WINDOW ? tli_pkg::WINDOW :
          (counts[p] > DEPTH ? DEPTH : counts[p]);
      calm = (p == 4);
      load_table(n);
      random_items(n, 140, p);
    end
    calm = 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d loads and %0d queries over six point counts (5 to 400),",
             loads_sent, queries_sent);
    $display("%0d results compared, %0d of them clipped, %0d mismatches.",
             results_seen, clipped_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("table_lagrange_interpolator_top verification clean");
    end else begin
      $display("table_lagrange_interpolator_top verification failed");
    end
    $finish;
  end

endmodule

[table_lagrange_interpolator_top.f]
rtl/tli_pkg.sv
rtl/tli_ram.sv
rtl/table_lagrange_interpolator_top.sv
tb/tb.sv
